@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante; skip while in reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check cons in the cycle after ante; skip while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/lrrs_pkg.sv @@
// Shared constants, types and the cell rule of the Life row stepper.
package lrrs_pkg;

   localparam int MAX_WIDTH = 64;
   localparam int WIDTH_BITS = 7;
   localparam logic [WIDTH_BITS-1:0] BOARD_WIDTH_RESET = 7'd64;
   localparam int FIFO_DEPTH = 4;
   localparam int PUSH_BITS = 2;

   // Neighbor count limits of rule B3/S23.
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Masked bits one cell shows to its neighbors.
   typedef struct packed {
      logic above;
      logic middle;
      logic fresh;
   } lrrs_tap_type;

   // Per-item control for all cells.
   typedef struct packed {
      logic load;
      logic last;
   } lrrs_cell_ctl_type;

   // Outputs of one cell.
   typedef struct packed {
      logic next_a;
      logic next_b;
      logic diff_a;
      logic diff_b;
   } lrrs_cell_out_type;

   // Both candidate results of the cell row for the current item.
   typedef struct packed {
      logic [MAX_WIDTH-1:0] next_a;
      logic [MAX_WIDTH-1:0] next_b;
      logic                 changed_a;
      logic                 changed_b;
   } lrrs_step_type;

   // One result word.
   typedef struct packed {
      logic [MAX_WIDTH-1:0] next_row_cells;
      logic                 row_changed;
      logic                 is_final_out;
      logic                 board_stable;
   } lrrs_result_type;

   // Up to two result words pushed in one cycle.
   typedef struct packed {
      logic [PUSH_BITS-1:0] count;
      lrrs_result_type      first;
      lrrs_result_type      second;
   } lrrs_push_type;

   // Queue status toward the control logic.
   typedef struct packed {
      logic valid;
      logic room;
   } lrrs_fifo_stat_type;

   // B3/S23: birth on three, survival on two or three.
   function automatic logic lrrs_life_rule(logic [3:0] count, logic alive);
      return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
   endfunction

endpackage

@@ sv/lrrs_channel_if.sv @@
// Handshake channels of the Life row stepper: request, response, register write.
interface lrrs_req_if;
   logic                          valid;
   logic                          ready;
   logic [lrrs_pkg::MAX_WIDTH-1:0] row_cells;
   logic                          is_last_row;
   modport source (output valid, output row_cells, output is_last_row, input ready);
   modport sink (input valid, input row_cells, input is_last_row, output ready);
endinterface

interface lrrs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lrrs_pkg::MAX_WIDTH-1:0] next_row_cells;
   logic                          row_changed;
   logic                          is_final_out;
   logic                          board_stable;
   modport source (output valid, output next_row_cells, output row_changed,
                   output is_final_out, output board_stable, input ready);
   modport sink (input valid, input next_row_cells, input row_changed,
                 input is_final_out, input board_stable, output ready);
endinterface

interface lrrs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [lrrs_pkg::WIDTH_BITS-1:0] board_width;
   modport source (output valid, output board_width, input ready);
   modport sink (input valid, input board_width, output ready);
endinterface

@@ sv/life_rule_row_stepper_unit.sv @@
// Top level of the Life B3/S23 row stepper.
//
// Rows of the board arrive on req_port, top row first, one word per row with
// is_last_row set on the bottom row. Results leave on rsp_port, one word per row,
// in row order; csr_port writes board_width and is always ready.
// A row's next generation is computed when the row below it is accepted; the
// bottom row also yields its own result, so that word pushes up to two results.
// The first row of a board yields nothing by itself unless it is the bottom row.
// The first result word is registered in the queue, valid in the cycle after
// the request word that releases it; the bottom row's own word follows once
// the first is taken. One request word per cycle while the queue has room, set
// by the 64-column cell chain that evaluates both window rows combinationally.
// A four-word result queue parts the two sides: req_port.ready is high while
// the queue has two free places, so a stalled receiver backs up the requests
// once more than two words wait. Nothing is lost while stalled.
// Reset clears the window, the board change flag and the queue, and sets
// board_width to 64. After the bottom row the window clears and the next word
// starts a new board.
module life_rule_row_stepper_unit (
   input  logic   clock,
   input  logic   reset,
   lrrs_req_if.sink   req_port,
   lrrs_rsp_if.source rsp_port,
   lrrs_csr_if.sink   csr_port
);
   import lrrs_pkg::*;

   logic [WIDTH_BITS-1:0] board_width_ff, board_width_in;
   logic rows_seen_ff, rows_seen_in;
   logic any_change_ff, any_change_in;
   logic accept;

   lrrs_cell_ctl_type  ctl;
   lrrs_step_type      step;
   lrrs_push_type      push;
   lrrs_result_type    head;
   lrrs_fifo_stat_type stat;

   assign csr_port.ready = 1'b1;
   assign req_port.ready = stat.room;
   assign accept = req_port.valid & req_port.ready;

   assign ctl.load = accept;
   assign ctl.last = req_port.is_last_row;

   lrrs_cell_row u_cell_row (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .row_cells   (req_port.row_cells),
      .board_width (board_width_ff),
      .step        (step)
   );

   // Build result words: first for the held row or a lone bottom row, second for the bottom row
   always_comb begin
      push.first.next_row_cells  = rows_seen_ff ? step.next_a : step.next_b;
      push.first.row_changed     = rows_seen_ff ? step.changed_a : step.changed_b;
      push.first.is_final_out    = !rows_seen_ff;
      push.first.board_stable    = !rows_seen_ff && !step.changed_b;
      push.second.next_row_cells = step.next_b;
      push.second.row_changed    = step.changed_b;
      push.second.is_final_out   = 1'b1;
      push.second.board_stable   = !(any_change_ff || step.changed_a || step.changed_b);
      push.count = '0;
      if (accept) begin
         push.count = PUSH_BITS'(rows_seen_ff) + PUSH_BITS'(req_port.is_last_row);
      end
   end

   // Track the window fill, board-wide change and the board width
   always_comb begin
      rows_seen_in   = rows_seen_ff;
      any_change_in  = any_change_ff;
      board_width_in = board_width_ff;
      if (accept) begin
         rows_seen_in  = !req_port.is_last_row;
         any_change_in = req_port.is_last_row ? 1'b0
                       : (any_change_ff || (rows_seen_ff && step.changed_a));
      end
      if (csr_port.valid && csr_port.ready) begin
         board_width_in = csr_port.board_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_width_ff <= BOARD_WIDTH_RESET;
         rows_seen_ff   <= 1'b0;
         any_change_ff  <= 1'b0;
      end else begin
         board_width_ff <= board_width_in;
         rows_seen_ff   <= rows_seen_in;
         any_change_ff  <= any_change_in;
      end
   end

   lrrs_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_port.valid & rsp_port.ready),
      .head  (head),
      .stat  (stat)
   );

   // Drive the result channel from the queue head
   assign rsp_port.valid          = stat.valid;
   assign rsp_port.next_row_cells = head.next_row_cells;
   assign rsp_port.row_changed    = head.row_changed;
   assign rsp_port.is_final_out   = head.is_final_out;
   assign rsp_port.board_stable   = head.board_stable;

endmodule

@@ sv/lrrs_cell.sv @@
// One column cell: holds the column bit of the two window rows and applies the rule.
module lrrs_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  lrrs_pkg::lrrs_cell_ctl_type  ctl,
   input  logic                         new_bit,
   input  logic                         mask_bit,
   input  lrrs_pkg::lrrs_tap_type       left_tap,
   input  lrrs_pkg::lrrs_tap_type       right_tap,
   output lrrs_pkg::lrrs_tap_type       own_tap,
   output lrrs_pkg::lrrs_cell_out_type  cell_out
);
   import lrrs_pkg::*;

   logic above_ff, above_in;
   logic middle_ff, middle_in;
   logic [3:0] count_a, count_b;
   logic rule_a, rule_b;

   // Show masked bits to the neighbors
   assign own_tap.above  = above_ff & mask_bit;
   assign own_tap.middle = middle_ff & mask_bit;
   assign own_tap.fresh  = new_bit & mask_bit;

   // Count neighbors for the held middle row (window above, middle, new row)
   assign count_a = 4'(left_tap.above) + 4'(own_tap.above) + 4'(right_tap.above)
                  + 4'(left_tap.middle) + 4'(right_tap.middle)
                  + 4'(left_tap.fresh) + 4'(own_tap.fresh) + 4'(right_tap.fresh);

   // Count neighbors for the new row with a dead row below it
   assign count_b = 4'(left_tap.middle) + 4'(own_tap.middle) + 4'(right_tap.middle)
                  + 4'(left_tap.fresh) + 4'(right_tap.fresh);

   assign rule_a = lrrs_life_rule(count_a, own_tap.middle);
   assign rule_b = lrrs_life_rule(count_b, own_tap.fresh);

   // Drop cells beyond the board width
   assign cell_out.next_a = rule_a & mask_bit;
   assign cell_out.next_b = rule_b & mask_bit;
   assign cell_out.diff_a = cell_out.next_a ^ own_tap.middle;
   assign cell_out.diff_b = cell_out.next_b ^ own_tap.fresh;

   // Shift the window down, or clear it after the bottom row
   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      if (ctl.load) begin
         if (ctl.last) begin
            above_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            above_in  = middle_ff;
            middle_in = new_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

endmodule

@@ sv/lrrs_cell_row.sv @@
// Chain of column cells with neighbor wiring, width mask and change reduction.
module lrrs_cell_row (
   input  logic                                clock,
   input  logic                                reset,
   input  lrrs_pkg::lrrs_cell_ctl_type         ctl,
   input  logic [lrrs_pkg::MAX_WIDTH-1:0]      row_cells,
   input  logic [lrrs_pkg::WIDTH_BITS-1:0]     board_width,
   output lrrs_pkg::lrrs_step_type             step
);
   import lrrs_pkg::*;

   lrrs_tap_type      tap [MAX_WIDTH];
   lrrs_tap_type      left_tap [MAX_WIDTH];
   lrrs_tap_type      right_tap [MAX_WIDTH];
   lrrs_cell_out_type cell_out [MAX_WIDTH];
   logic [MAX_WIDTH-1:0] mask;
   logic [MAX_WIDTH-1:0] diff_a, diff_b;

   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
      // Columns at and above the width are dead
      assign mask[c] = WIDTH_BITS'(c) < board_width;

      // Dead border beyond the outer columns
      if (c == 0) begin : g_left_edge
         assign left_tap[c] = '0;
      end else begin : g_left
         assign left_tap[c] = tap[c-1];
      end
      if (c == MAX_WIDTH - 1) begin : g_right_edge
         assign right_tap[c] = '0;
      end else begin : g_right
         assign right_tap[c] = tap[c+1];
      end

      lrrs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_bit   (row_cells[c]),
         .mask_bit  (mask[c]),
         .left_tap  (left_tap[c]),
         .right_tap (right_tap[c]),
         .own_tap   (tap[c]),
         .cell_out  (cell_out[c])
      );

      assign step.next_a[c] = cell_out[c].next_a;
      assign step.next_b[c] = cell_out[c].next_b;
      assign diff_a[c]      = cell_out[c].diff_a;
      assign diff_b[c]      = cell_out[c].diff_b;
   end

   // Reduce per-column differences to row change flags
   assign step.changed_a = |diff_a;
   assign step.changed_b = |diff_b;

endmodule

@@ sv/lrrs_rsp_fifo.sv @@
// Small result queue that takes up to two words per cycle and drains one.
module lrrs_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  lrrs_pkg::lrrs_push_type       push,
   input  logic                          pop,
   output lrrs_pkg::lrrs_result_type     head,
   output lrrs_pkg::lrrs_fifo_stat_type  stat
);
   import lrrs_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

   lrrs_result_type  entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.valid = count_ff != '0;
   assign stat.room  = count_ff <= ROOM_LIMIT;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed words in order
   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == PUSH_BITS'(2)) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule

@@ sv/lrrs_checker.sv @@
// Port-level checker for the Life row stepper and its bind to the top level.
`include "assert_macros.svh"

module lrrs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [lrrs_pkg::MAX_WIDTH-1:0] rsp_next_row_cells,
   input logic                           rsp_row_changed,
   input logic                           rsp_is_final_out,
   input logic                           rsp_board_stable
);
   import lrrs_pkg::*;

   logic stall;
   assign stall = rsp_valid && !rsp_ready;

   // Hold a stalled result word
   `ASSERT_NEXT(a_rsp_hold_valid, clock, reset, stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_hold_data, clock, reset, stall, $stable(rsp_next_row_cells))

   // A stable board is reported only on the bottom row's word
   `ASSERT_SAME(a_stable_on_final, clock, reset, rsp_valid && rsp_board_stable,
                rsp_is_final_out)

   // A stable board cannot carry a changed row
   `ASSERT_SAME(a_stable_no_change, clock, reset, rsp_valid && rsp_board_stable,
                !rsp_row_changed)

endmodule

bind life_rule_row_stepper_unit lrrs_checker u_lrrs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_next_row_cells (rsp_port.next_row_cells),
   .rsp_row_changed    (rsp_port.row_changed),
   .rsp_is_final_out   (rsp_port.is_final_out),
   .rsp_board_stable   (rsp_port.board_stable)
);
